// ===== design/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types, constants and helpers for the arp responder with cache
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int CACHE_ENTRIES = 8;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int FRAME_LEN = 60;
	localparam int MIN_LEN = 42;

	localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
	localparam logic [15:0] PROTO_IPV4 = 16'h0800;
	localparam logic [15:0] HW_ETHER = 16'h0001;
	localparam logic [15:0] LENGTHS_OK = 16'h0604;
	localparam logic [15:0] OP_REQUEST = 16'h0001;
	localparam logic [15:0] OP_REPLY = 16'h0002;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		CMD_BYTE = 3'd0,
		CMD_LOOKUP = 3'd1,
		CMD_FLUSH = 3'd2,
		CMD_REQUEST = 3'd3,
		CMD_ANNOUNCE = 3'd4
	} cmd_t;

	localparam logic [1:0] REG_OWN_IP = 2'd0;
	localparam logic [1:0] REG_OWN_MAC = 2'd1;
	localparam logic [1:0] REG_LINK = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEARN,
		ST_LOOKUP,
		ST_TX,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_in;     // register the incoming item
		logic do_byte;     // capture a frame byte
		logic do_flush;    // clear the cache
		logic do_learn;    // write the learned sender
		logic do_lookup;   // load the lookup answer
		logic start_tx;    // load frame fields, reset byte index
		logic tx_step;     // advance transmit byte index
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic frame_ok;    // last byte closes a valid arp frame
		logic reply_due;   // frame asks for our address
		logic ip_zero;
		logic link;
		logic tx_end;      // current tx byte is the last one
	} sts_t;

endpackage

// ===== design/arpc_if.sv =====
// ----------------------------------------------------------------------------
// arpc_if
// valid/ready channel interfaces for items, results and config writes
// ----------------------------------------------------------------------------
interface arpc_in_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic [7:0] data_byte;
	logic frame_last;
	logic [31:0] ip_value;
	modport source (output valid, command, data_byte, frame_last, ip_value, input ready);
	modport sink (input valid, command, data_byte, frame_last, ip_value, output ready);
endinterface

interface arpc_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] tx_byte;
	logic tx_last;
	logic hit;
	logic [47:0] found_mac;
	modport source (output valid, kind, tx_byte, tx_last, hit, found_mac, input ready);
	modport sink (input valid, kind, tx_byte, tx_last, hit, found_mac, output ready);
endinterface

interface arpc_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/arpc_datapath.sv =====
// ----------------------------------------------------------------------------
// arpc_datapath
// receive capture, cache storage, lookup and transmit byte generation
// ----------------------------------------------------------------------------
module arpc_datapath
	import arpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [2:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        frame_last,
	input  logic [31:0] ip_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic        hit,
	output logic [47:0] found_mac
);

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic        link_q;
	logic [2:0]  cmd_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [31:0] ipv_q;
	logic [5:0]  rx_count_q;
	logic [15:0] eth_type_q, hw_type_q, proto_q, lengths_q, opcode_q;
	logic [47:0] smac_q;
	logic [31:0] sip_q, tip_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [31:0] eip_q [CACHE_ENTRIES];
	logic [47:0] emac_q [CACHE_ENTRIES];
	logic [47:0] f_dest_q, f_tmac_q;
	logic [31:0] f_tip_q, f_sip_q;
	logic [15:0] f_op_q;
	logic [5:0]  tx_idx_q;
	logic        kind_q, hit_q;
	logic [47:0] fmac_q;
	logic [5:0]  len;
	logic [CACHE_ENTRIES-1:0] match;
	logic        any_match, any_free;
	logic [IDX_W-1:0] match_idx, free_idx, wr_idx;
	logic [7:0]  b;
	logic        long_q;
	logic [31:0] key;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			own_mac_q <= '0;
			link_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_IP: own_ip_q <= cfg_data[31:0];
				REG_OWN_MAC: own_mac_q <= cfg_data;
				REG_LINK: link_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input item register
	always_ff @(posedge clk) begin
		if (ctl.take_in) begin
			cmd_q <= command;
			byte_q <= data_byte;
			last_q <= frame_last;
			ipv_q <= ip_value;
		end
	end

	// frame length after this byte, saturated
	assign len = (rx_count_q < 6'd63) ? rx_count_q + 6'd1 : rx_count_q;

	// receive capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
			eth_type_q <= '0; hw_type_q <= '0; proto_q <= '0;
			lengths_q <= '0; opcode_q <= '0; smac_q <= '0;
			sip_q <= '0; tip_q <= '0;
		end else if (ctl.do_byte) begin
			rx_count_q <= last_q ? 6'd0 : len;
			if (rx_count_q == 6'd12 || rx_count_q == 6'd13)
				eth_type_q <= {eth_type_q[7:0], byte_q};
			else if (rx_count_q == 6'd14 || rx_count_q == 6'd15)
				hw_type_q <= {hw_type_q[7:0], byte_q};
			else if (rx_count_q == 6'd16 || rx_count_q == 6'd17)
				proto_q <= {proto_q[7:0], byte_q};
			else if (rx_count_q == 6'd18 || rx_count_q == 6'd19)
				lengths_q <= {lengths_q[7:0], byte_q};
			else if (rx_count_q == 6'd20 || rx_count_q == 6'd21)
				opcode_q <= {opcode_q[7:0], byte_q};
			else if (rx_count_q >= 6'd22 && rx_count_q <= 6'd27)
				smac_q <= {smac_q[39:0], byte_q};
			else if (rx_count_q >= 6'd28 && rx_count_q <= 6'd31)
				sip_q <= {sip_q[23:0], byte_q};
			else if (rx_count_q >= 6'd38 && rx_count_q <= 6'd41)
				tip_q <= {tip_q[23:0], byte_q};
		end
	end

	// frame check, evaluated after the last byte has been captured
	always_comb begin
		sts.cmd = cmd_t'(cmd_q);
		sts.frame_ok = long_q && (eth_type_q == ETH_TYPE_ARP) && (hw_type_q == HW_ETHER) &&
			(proto_q == PROTO_IPV4) && (lengths_q == LENGTHS_OK);
		sts.reply_due = (opcode_q == OP_REQUEST) && (own_ip_q != '0) &&
			(tip_q == own_ip_q);
		sts.ip_zero = (ipv_q == '0);
		sts.link = link_q;
		sts.tx_end = (tx_idx_q == 6'(FRAME_LEN - 1));
	end

	// frame length test needs the count before clearing; held in a flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			long_q <= 1'b0;
		else if (ctl.do_byte)
			long_q <= last_q && (len >= 6'(MIN_LEN));
	end

	// cache match against the learn key or the lookup key
	assign key = ctl.do_lookup ? ipv_q : sip_q;
	always_comb begin
		any_match = 1'b0; any_free = 1'b0;
		match_idx = '0; free_idx = '0;
		for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (eip_q[i] == key);
			if (match[i]) begin
				any_match = 1'b1;
				match_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
		wr_idx = any_match ? match_idx : (any_free ? free_idx : '0);
	end

	// cache storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (ctl.do_flush)
			valid_q <= '0;
		else if (ctl.do_learn && long_q && sip_q != '0)
			valid_q[wr_idx] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.do_learn && long_q && sip_q != '0) begin
			eip_q[wr_idx] <= sip_q;
			emac_q[wr_idx] <= smac_q;
		end
	end

	// result fields and transmit frame fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_idx_q <= '0;
			kind_q <= 1'b0;
		end else if (ctl.do_lookup) begin
			kind_q <= 1'b1;
		end else if (ctl.start_tx) begin
			kind_q <= 1'b0;
			tx_idx_q <= '0;
		end else if (ctl.tx_step) begin
			tx_idx_q <= tx_idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_lookup) begin
			hit_q <= any_match && !sts.ip_zero;
			fmac_q <= (any_match && !sts.ip_zero) ? emac_q[match_idx] : '0;
		end
		if (ctl.start_tx) begin
			if (cmd_q == CMD_BYTE) begin
				f_dest_q <= smac_q; f_tmac_q <= smac_q;
				f_tip_q <= sip_q; f_sip_q <= own_ip_q; f_op_q <= OP_REPLY;
			end else begin
				f_dest_q <= MAC_BCAST; f_tmac_q <= '0; f_tip_q <= ipv_q;
				f_sip_q <= (cmd_q == CMD_ANNOUNCE) ? ipv_q : own_ip_q;
				f_op_q <= OP_REQUEST;
			end
		end
	end

	// transmit byte select
	always_comb begin
		b = 8'h00;
		if (tx_idx_q < 6'd6) b = f_dest_q[8*(5-tx_idx_q) +: 8];
		else if (tx_idx_q < 6'd12) b = own_mac_q[8*(11-tx_idx_q) +: 8];
		else if (tx_idx_q == 6'd12) b = ETH_TYPE_ARP[15:8];
		else if (tx_idx_q == 6'd13) b = ETH_TYPE_ARP[7:0];
		else if (tx_idx_q == 6'd14) b = HW_ETHER[15:8];
		else if (tx_idx_q == 6'd15) b = HW_ETHER[7:0];
		else if (tx_idx_q == 6'd16) b = PROTO_IPV4[15:8];
		else if (tx_idx_q == 6'd17) b = PROTO_IPV4[7:0];
		else if (tx_idx_q == 6'd18) b = LENGTHS_OK[15:8];
		else if (tx_idx_q == 6'd19) b = LENGTHS_OK[7:0];
		else if (tx_idx_q == 6'd20) b = f_op_q[15:8];
		else if (tx_idx_q == 6'd21) b = f_op_q[7:0];
		else if (tx_idx_q < 6'd28) b = own_mac_q[8*(27-tx_idx_q) +: 8];
		else if (tx_idx_q < 6'd32) b = f_sip_q[8*(31-tx_idx_q) +: 8];
		else if (tx_idx_q < 6'd38) b = f_tmac_q[8*(37-tx_idx_q) +: 8];
		else if (tx_idx_q < 6'd42) b = f_tip_q[8*(41-tx_idx_q) +: 8];
	end

	assign kind = kind_q;
	assign tx_byte = kind_q ? 8'h00 : b;
	assign tx_last = !kind_q && sts.tx_end;
	assign hit = kind_q && hit_q;
	assign found_mac = kind_q ? fmac_q : '0;

endmodule

// ===== design/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// sequencing of receive, learn, lookup and transmit
// ----------------------------------------------------------------------------
module arpc_ctrl
	import arpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic   busy_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (busy_q) begin
				unique case (sts.cmd)
					CMD_BYTE: state_d = ST_LEARN;
					CMD_LOOKUP: state_d = ST_LOOKUP;
					CMD_REQUEST: if (sts.link) state_d = ST_TX;
					CMD_ANNOUNCE: if (!sts.ip_zero) state_d = ST_TX;
					default: ;
				endcase
			end
			ST_LEARN: state_d = ST_IDLE;
			ST_LOOKUP: state_d = ST_OUT;
			ST_TX: if (out_ready && sts.tx_end) state_d = ST_IDLE;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_LEARN && sts.frame_ok && sts.reply_due)
			state_d = ST_TX;
	end

	// outputs
	always_comb begin
		ctl = '0;
		in_ready = (state_q == ST_IDLE) && !busy_q;
		out_valid = (state_q == ST_TX) || (state_q == ST_OUT);
		ctl.take_in = in_valid && in_ready;
		ctl.do_byte = (state_q == ST_IDLE) && busy_q && (sts.cmd == CMD_BYTE);
		ctl.do_flush = (state_q == ST_IDLE) && busy_q && (sts.cmd == CMD_FLUSH);
		ctl.do_lookup = (state_q == ST_LOOKUP);
		ctl.do_learn = (state_q == ST_LEARN) && sts.frame_ok;
		ctl.start_tx = (state_d == ST_TX) && (state_q != ST_TX);
		ctl.tx_step = (state_q == ST_TX) && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q <= ctl.take_in;
		end
	end

endmodule

// ===== design/arp_responder_with_cache.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// arp responder over ethernet/ipv4 with an ip-to-mac cache
// ----------------------------------------------------------------------------
// Items enter on in_ch: a frame byte, lookup, flush, request or announce.
// Results leave on out_ch: 60 transmit bytes per frame or one lookup answer.
// Registers own_ip, own_mac and link_present are written over cfg_ch.
// Every frame byte passes three steps (register, capture, frame check); on
// the last byte the check learns the sender into the cache and starts a
// reply if due, and a new byte is taken only after the frame check of the
// one before. The first reply byte is valid after those steps; a lookup
// answer after register, dispatch and lookup; the first byte of a request
// or announce after register and dispatch. A frame goes out one byte a
// cycle while out_ch is ready; the byte index counter sets that rate.
// A stalled receiver holds the current byte; no new item is taken until
// all results of the present one are delivered.
// Reset clears the cache valid bits, the capture state and the registers.
// ----------------------------------------------------------------------------
module arp_responder_with_cache
	import arpc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	arpc_in_if.sink in_ch,
	arpc_out_if.source out_ch,
	arpc_cfg_if.sink cfg_ch
);

	ctl_t ctl;
	sts_t sts;

	assign cfg_ch.ready = 1'b1;

	arpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .ctl(ctl)
	);

	arpc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.command(in_ch.command), .data_byte(in_ch.data_byte),
		.frame_last(in_ch.frame_last), .ip_value(in_ch.ip_value),
		.cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
		.kind(out_ch.kind), .tx_byte(out_ch.tx_byte), .tx_last(out_ch.tx_last),
		.hit(out_ch.hit), .found_mac(out_ch.found_mac)
	);

	// no item accepted while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("item accepted during output");
	// lookup answers never carry the last-byte mark
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind |-> !out_ch.tx_last) else $error("bad lookup answer");
	// a miss reports a zero mac
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind && !out_ch.hit |-> out_ch.found_mac == '0)
		else $error("miss with mac");

endmodule
